// File: rtl/stmf_pkg.sv
// ----------------------------------------------------------------------------
// stmf_pkg
// Shared types and constants for the sliding trimmed-mean filter.
// ----------------------------------------------------------------------------
package stmf_pkg;

    localparam int SAMPLE_W = 16;
    localparam int MEAN_W   = 24;
    localparam int TRIM_W   = 2;
    localparam int FRAC_W   = 8;

    localparam logic [0:0] REG_TRIM_COUNT = 1'd0;
    localparam logic [TRIM_W-1:0] TRIM_RESET = 2'd1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;      // write sample into ring, update running sum
        logic scan_clr;  // start a new min/max search pass
        logic scan_step; // compare one ring entry
        logic trim_sub;  // remove the found min and max from the sum
        logic div_init;  // load the divider
        logic div_step;  // one restoring step
        logic out_load;  // latch the result
    } stmf_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic div_last;
    } stmf_sts_t;

endpackage

// File: rtl/sliding_trimmed_mean_filter.sv
// ----------------------------------------------------------------------------
// sliding_trimmed_mean_filter
// Trimmed mean of the last WINDOW samples, Q.8, one result per sample.
// ----------------------------------------------------------------------------
// One sample at a time: after acceptance the block makes trim passes over the
// ring of WINDOW entries to find and remove the smallest and largest
// remaining samples, then runs a one-bit-per-cycle restoring divider over the
// sum width plus 8 fraction bits. The next sample is taken while the result
// waits, and a result not yet taken stalls only the result load of the
// following sample. The trim is clamped to (WINDOW-1)/2 and the clamp is
// flagged in trim_clamped. The ring is zero after reset.
module sliding_trimmed_mean_filter #(
    parameter int WINDOW = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [stmf_pkg::SAMPLE_W-1:0] s_sample,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [stmf_pkg::MEAN_W-1:0] m_mean_q8,
    output logic                               m_trim_clamped
);
    import stmf_pkg::*;

    localparam logic [TRIM_W-1:0] MAX_TRIM = TRIM_W'((WINDOW - 1) / 2 > 3 ? 3 : (WINDOW - 1) / 2);

    logic [TRIM_W-1:0] trim_count_reg;
    logic [TRIM_W-1:0] trim_eff;
    logic clamp_reg;
    stmf_cmd_t cmd;
    stmf_sts_t sts;

    assign pready = 1'b1;
    assign prdata = (paddr[1] == REG_TRIM_COUNT) ? {30'd0, trim_count_reg} : 32'd0;
    assign trim_eff = (trim_count_reg > MAX_TRIM) ? MAX_TRIM : trim_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trim_count_reg <= TRIM_RESET;
        end else if (psel && penable && pwrite && paddr[1] == REG_TRIM_COUNT) begin
            trim_count_reg <= pwdata[TRIM_W-1:0];
        end
    end

    // Load the flag together with the mean
    always_ff @(posedge aclk) begin
        if (cmd.out_load) clamp_reg <= (trim_count_reg > MAX_TRIM);
    end
    assign m_trim_clamped = clamp_reg;

    stmf_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready,
        .trim(trim_eff), .sts, .cmd
    );

    stmf_datapath #(.WINDOW(WINDOW)) u_dp (
        .aclk, .aresetn, .sample(s_sample), .trim(trim_eff), .cmd, .sts,
        .mean_q8(m_mean_q8)
    );

endmodule

// File: rtl/stmf_datapath.sv
// ----------------------------------------------------------------------------
// stmf_datapath
// Ring of samples, running sum, min/max search over the ring, trim removal
// and a restoring divider.
// ----------------------------------------------------------------------------
module stmf_datapath #(
    parameter int WINDOW = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic signed [stmf_pkg::SAMPLE_W-1:0] sample,
    input  logic [stmf_pkg::TRIM_W-1:0]   trim,
    input  stmf_pkg::stmf_cmd_t           cmd,
    output stmf_pkg::stmf_sts_t           sts,
    output logic signed [stmf_pkg::MEAN_W-1:0] mean_q8
);
    import stmf_pkg::*;

    localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W = SAMPLE_W + $clog2(WINDOW) + 1;
    localparam int NUM_W = SUM_W + FRAC_W;
    localparam int DIV_W = $clog2(WINDOW + 1);
    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);

    logic signed [SAMPLE_W-1:0] ring_reg [WINDOW];
    logic [WINDOW-1:0] used_reg, used_next;
    logic [IDX_W-1:0] wr_reg, wr_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic signed [SUM_W-1:0] rest_reg, rest_next;
    logic [IDX_W-1:0] scan_reg, scan_next;
    logic [IDX_W-1:0] min_idx_reg, min_idx_next, max_idx_reg, max_idx_next;
    logic first_reg, first_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [NUM_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] dcnt_reg, dcnt_next;
    logic neg_reg, neg_next;
    logic [DIV_W-1:0] divisor;
    logic [NUM_W:0] trial;
    logic signed [SAMPLE_W-1:0] cur, cmin, cmax;
    logic [NUM_W-1:0] mag;
    logic signed [NUM_W-1:0] num;

    assign divisor = DIV_W'(WINDOW) - DIV_W'({trim, 1'b0});
    assign cur  = ring_reg[scan_reg];
    assign cmin = ring_reg[min_idx_reg];
    assign cmax = ring_reg[max_idx_reg];
    assign num  = {rest_reg, {FRAC_W{1'b0}}};
    assign mag  = num[NUM_W-1] ? NUM_W'(-num) : num;
    assign trial = {rem_reg, quo_reg[NUM_W-1]} - (NUM_W+1)'(divisor);

    always_comb begin
        used_next = used_reg;
        wr_next = wr_reg;
        sum_next = sum_reg;
        rest_next = rest_reg;
        scan_next = scan_reg;
        min_idx_next = min_idx_reg;
        max_idx_next = max_idx_reg;
        first_next = first_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        dcnt_next = dcnt_reg;
        neg_next = neg_reg;
        if (cmd.load) begin
            sum_next = sum_reg - SUM_W'(ring_reg[wr_reg]) + SUM_W'(sample);
            rest_next = sum_next;
            wr_next = (wr_reg == LAST_IDX) ? '0 : wr_reg + 1'b1;
            used_next = '0;
        end
        if (cmd.scan_clr) begin
            scan_next = '0;
            first_next = 1'b1;
        end
        // Skip entries already trimmed; ties resolve to one entry each side
        if (cmd.scan_step) begin
            if (!used_reg[scan_reg]) begin
                if (first_reg) begin
                    min_idx_next = scan_reg;
                    max_idx_next = scan_reg;
                    first_next = 1'b0;
                end else begin
                    if (cur < cmin) min_idx_next = scan_reg;
                    if (cur >= cmax) max_idx_next = scan_reg;
                end
            end
            scan_next = scan_reg + 1'b1;
        end
        if (cmd.trim_sub) begin
            rest_next = rest_reg - SUM_W'(cmin) - SUM_W'(cmax);
            used_next[min_idx_reg] = 1'b1;
            used_next[max_idx_reg] = 1'b1;
        end
        if (cmd.div_init) begin
            quo_next = mag;
            rem_next = '0;
            dcnt_next = '0;
            neg_next = num[NUM_W-1];
        end
        if (cmd.div_step) begin
            if (!trial[NUM_W]) rem_next = trial[NUM_W-1:0];
            else rem_next = {rem_reg[NUM_W-2:0], quo_reg[NUM_W-1]};
            quo_next = {quo_reg[NUM_W-2:0], !trial[NUM_W]};
            dcnt_next = dcnt_reg + 1'b1;
        end
    end

    assign sts.scan_last = (scan_reg == LAST_IDX);
    assign sts.div_last  = (dcnt_reg == CNT_W'(NUM_W - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WINDOW; i++) ring_reg[i] <= '0;
            wr_reg <= '0;
            sum_reg <= '0;
        end else begin
            if (cmd.load) ring_reg[wr_reg] <= sample;
            wr_reg <= wr_next;
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        used_reg <= used_next;
        rest_reg <= rest_next;
        scan_reg <= scan_next;
        min_idx_reg <= min_idx_next;
        max_idx_reg <= max_idx_next;
        first_reg <= first_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dcnt_reg <= dcnt_next;
        neg_reg <= neg_next;
        if (cmd.out_load)
            mean_q8 <= neg_reg ? MEAN_W'(-quo_reg) : MEAN_W'(quo_reg);
    end

    // The write pointer always stays within the ring
    property p_wr_range;
        @(posedge aclk) disable iff (!aresetn) wr_reg <= LAST_IDX;
    endproperty
    a_wr_range: assert property (p_wr_range) else $error("write pointer out of range");

    a_excl_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.scan_step && cmd.div_step)) else $error("scan and divide overlap");

    a_trim_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.trim_sub |-> (min_idx_reg != max_idx_reg))
        else $error("min and max coincide");

endmodule

// File: rtl/stmf_ctrl.sv
// ----------------------------------------------------------------------------
// stmf_ctrl
// Sequencer: load, trim passes over the ring, divide, present the result.
// ----------------------------------------------------------------------------
module stmf_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    output logic                        m_valid,
    input  logic                        m_ready,
    input  logic [stmf_pkg::TRIM_W-1:0] trim,
    input  stmf_pkg::stmf_sts_t         sts,
    output stmf_pkg::stmf_cmd_t         cmd
);
    import stmf_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SCAN = 6'b000010,
        ST_SUB  = 6'b000100,
        ST_DIV  = 6'b001000,
        ST_OUT  = 6'b010000,
        ST_INIT = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [TRIM_W-1:0] pass_reg, pass_next;
    logic m_valid_reg, m_valid_next;

    // Take the next sample while the previous result still waits at the output
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        pass_next = pass_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.load = 1'b1;
                    cmd.scan_clr = 1'b1;
                    pass_next = '0;
                    state_next = (trim == '0) ? ST_INIT : ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last) state_next = ST_SUB;
            end
            ST_SUB: begin
                cmd.trim_sub = 1'b1;
                cmd.scan_clr = 1'b1;
                pass_next = pass_reg + 1'b1;
                state_next = (pass_next == trim) ? ST_INIT : ST_SCAN;
            end
            ST_INIT: begin
                cmd.div_init = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) state_next = ST_OUT;
            end
            ST_OUT: begin
                // Hold until the output slot is free
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pass_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            pass_reg <= pass_next;
            m_valid_reg <= m_valid_next;
        end
    end

    a_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg)) else $error("state not one-hot");
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready)) else $error("result overwritten");
    a_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (pass_reg < trim)) else $error("extra trim pass");

endmodule

// File: tb/tb_sliding_trimmed_mean_filter.sv
// ----------------------------------------------------------------------------
// Sliding trimmed-mean filter testbench
// Streams samples through the filter under random back-pressure, predicts
// each trimmed mean from a local copy of the window and checks the results
// in order. The trim register is swept over all values.
// ----------------------------------------------------------------------------
module tb_sliding_trimmed_mean_filter;
    import stmf_pkg::*;

    localparam int WIN = 8;
    localparam int MAX_TRIM = (WIN - 1) / 2;

    typedef struct packed {
        logic signed [MEAN_W-1:0] mean_q8;
        logic                     clamped;
    } mean_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [SAMPLE_W-1:0] s_sample = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [MEAN_W-1:0] m_mean_q8;
    logic m_trim_clamped;

    sliding_trimmed_mean_filter #(.WINDOW(WIN)) u_top (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    logic signed [SAMPLE_W-1:0] sample_q[$];
    mean_t means_due[$];
    int mismatches = 0;
    int src_idle = 0, snk_idle = 0;
    bit src_hold = 1'b0;

    // predictor state
    logic signed [SAMPLE_W-1:0] ring[WIN];
    int ring_pos = 0;
    logic [1:0] trim_reg = TRIM_RESET;

    function automatic mean_t predict_mean(logic signed [SAMPLE_W-1:0] smp);
        longint sorted[WIN];
        longint key, rest, sum;
        int t, j;
        mean_t res;
        ring[ring_pos] = smp;
        ring_pos = (ring_pos + 1) % WIN;
        sum = 0;
        for (int i = 0; i < WIN; i++) begin
            sorted[i] = ring[i];
            sum += ring[i];
        end
        for (int i = 1; i < WIN; i++) begin
            key = sorted[i];
            j = i - 1;
            while (j >= 0 && sorted[j] > key) begin
                sorted[j+1] = sorted[j];
                j--;
            end
            sorted[j+1] = key;
        end
        t = trim_reg;
        res.clamped = (t > MAX_TRIM);
        if (t > MAX_TRIM) t = MAX_TRIM;
        rest = sum;
        for (int r = 0; r < t; r++) rest -= sorted[r] + sorted[WIN-1-r];
        res.mean_q8 = MEAN_W'((rest * 256) / (WIN - 2 * t));
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d", what, got, want);
        mismatches++;
    endtask

    // driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                means_due.push_back(predict_mean(s_sample));
                void'(sample_q.pop_front());
            end
            if (!s_valid || s_ready) begin
                if (sample_q.size() > 0 && !src_hold && $urandom_range(99) >= src_idle) begin
                    s_valid <= 1'b1;
                    s_sample <= sample_q[0];
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(99) >= snk_idle);
        end
    end

    // monitor
    always @(posedge aclk) begin
        mean_t want;
        if (aresetn && m_valid && m_ready) begin
            if (means_due.size() == 0) begin
                report_mismatch("unexpected result", m_mean_q8, 0);
            end else begin
                want = means_due.pop_front();
                if (m_mean_q8 !== want.mean_q8)
                    report_mismatch("mean_q8", m_mean_q8, want.mean_q8);
                if (m_trim_clamped !== want.clamped)
                    report_mismatch("trim_clamped", m_trim_clamped, want.clamped);
            end
        end
    end

    task automatic write_trim(logic [31:0] val);
        @(posedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= 2'd0; pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        trim_reg = val[1:0];
    endtask

    task automatic drain();
        while (sample_q.size() > 0 || s_valid || means_due.size() > 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return SAMPLE_W'(int'($urandom_range(31)) - 16);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic run_random(int n, int si, int ki);
        src_idle = si; snk_idle = ki;
        for (int i = 0; i < n; i++) sample_q.push_back(rand_sample());
        drain();
    endtask

    initial begin
        for (int i = 0; i < WIN; i++) ring[i] = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        // directed: reset trim, extremes, zeros in the window
        src_idle = 20; snk_idle = 20;
        sample_q.push_back(16'sh7FFF); sample_q.push_back(16'sh8000);
        sample_q.push_back(16'sh0000); sample_q.push_back(16'shFFFF);
        sample_q.push_back(16'sh0001); sample_q.push_back(16'sh5555);
        sample_q.push_back(16'shAAAA); sample_q.push_back(16'sh7FFF);
        drain();
        for (int t = 0; t < 4; t++) begin
            write_trim(32'hFFFF_FFFC | t);
            for (int i = 0; i < 4; i++) sample_q.push_back(rand_sample());
            sample_q.push_back(16'sh8000); sample_q.push_back(16'sh7FFF);
            drain();
        end
        write_trim(32'd3);
        run_random(80, 33, 46);
        write_trim(32'd0);
        run_random(80, 46, 33);
        write_trim(32'd2);
        run_random(80, 0, 0);
        // hold the sender until all results are in, then resume
        src_idle = 10; snk_idle = 10;
        for (int i = 0; i < 20; i++) sample_q.push_back(rand_sample());
        repeat (200) @(posedge aclk);
        src_hold = 1'b1;
        while (s_valid || means_due.size() > 0) @(posedge aclk);
        src_hold = 1'b0;
        drain();
        write_trim(32'd1);
        run_random(70, 33, 46);
        write_trim(32'd3);
        run_random(70, 46, 33);
        write_trim(32'd0);
        run_random(70, 0, 0);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("Test completed with failures");
        $finish;
    end
endmodule

// File: sim.f
rtl/stmf_pkg.sv
rtl/stmf_datapath.sv
rtl/stmf_ctrl.sv
rtl/sliding_trimmed_mean_filter.sv
tb/tb_sliding_trimmed_mean_filter.sv
